@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge once reset is released
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/btc_pkg.sv @@
`default_nettype none

package btc_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // field widths
    localparam int DATA_W     = 32;
    localparam int ANG_W      = 16;
    localparam int S_DATA_W   = 128;
    localparam int M_USER_W   = 2;
    localparam int MASS_W     = 23;
    localparam int GRAV_W     = 22;
    localparam int VGAIN_W    = 23;
    localparam int PGAIN_W    = 23;
    localparam int THR_W      = 31;
    localparam int GFLOOR_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // datapath widths
    localparam int POLY_W = 31;
    localparam int COS_W  = FRAC_BITS + 2;
    localparam int PROD_W = 2 * FRAC_BITS + 1;
    // numerator magnitude is bounded by the speed and altitude products
    localparam int NUM_W  = 57;
    localparam int QUO_W  = NUM_W - 1;

    localparam logic [POLY_W-1:0] ONE30   = 31'h4000_0000;
    localparam logic [POLY_W-1:0] COS_C1  = 31'd1324675879;
    localparam logic [POLY_W-1:0] COS_C2  = 31'd272375560;
    localparam logic [POLY_W-1:0] COS_C3  = 31'd22401992;
    localparam logic [POLY_W-1:0] COS_C4  = 31'd987048;
    localparam logic [POLY_W-1:0] COS_C5  = 31'd27061;
    localparam logic [POLY_W-1:0] COS_RND = POLY_W'(1 << (29 - FRAC_BITS));

    localparam logic [MASS_W-1:0]   MASS_RST   = 23'd131072;
    localparam logic [GRAV_W-1:0]   GRAV_RST   = 22'd642908;
    localparam logic [VGAIN_W-1:0]  VGAIN_RST  = 23'd131072;
    localparam logic [PGAIN_W-1:0]  PGAIN_RST  = 23'd65536;
    localparam logic [THR_W-1:0]    CEIL_RST   = 31'd5143265;
    localparam logic [THR_W-1:0]    FLOOR_RST  = 31'd0;
    localparam logic [GFLOOR_W-1:0] GFLOOR_RST = 17'd655;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASS    = 3'd0,
        REG_GRAVITY = 3'd1,
        REG_VGAIN   = 3'd2,
        REG_PGAIN   = 3'd3,
        REG_CEILING = 3'd4,
        REG_FLOOR   = 3'd5,
        REG_GFLOOR  = 3'd6
    } cfg_reg_t;

    typedef enum logic [M_USER_W-1:0] {
        KIND_PASS   = 2'd0,
        KIND_RAISED = 2'd1,
        KIND_CAPPED = 2'd2
    } clamp_kind_t;

    // (a*b) >> 30 for the cosine polynomial
    function automatic logic [POLY_W-1:0] mul_shr30(input logic [POLY_W-1:0] a,
                                                    input logic [POLY_W-1:0] b);
        logic [2*POLY_W-1:0] p;
        p = (2*POLY_W)'(a) * (2*POLY_W)'(b);
        return p[POLY_W+29:30];
    endfunction

endpackage

`default_nettype wire

@@ rtl/barrier_thrust_clamp_top.sv @@
// pipeline: 101 register stages from the input transfer to the offered result
// throughput: one item per clock; the two cosine polynomials, the 33-stage gain divider
// and the 56-stage bound divider are fully pipelined, one quotient bit per stage
// a stall on the result side freezes the whole pipeline, nothing is dropped
// reset (aresetn low, synchronous) clears all valid bits and loads the register defaults
`default_nettype none
`include "assert_macros.svh"

module barrier_thrust_clamp_top (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // altitude, climb_rate, roll_angle, pitch_angle, nominal_thrust
    input  wire  [btc_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // safe_thrust
    output logic [btc_pkg::DATA_W-1:0]         m_tdata,
    // clamp_kind
    output logic [btc_pkg::M_USER_W-1:0]       m_tuser,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [btc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [btc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int FRAC_BITS  = btc_pkg::FRAC_BITS;
    localparam int ANGLE_BITS = btc_pkg::ANGLE_BITS;
    localparam int DATA_W     = btc_pkg::DATA_W;
    localparam int ANG_W      = btc_pkg::ANG_W;
    localparam int POLY_W     = btc_pkg::POLY_W;
    localparam int COS_W      = btc_pkg::COS_W;
    localparam int PROD_W     = btc_pkg::PROD_W;
    localparam int NUM_W      = btc_pkg::NUM_W;
    localparam int QUO_W      = btc_pkg::QUO_W;
    localparam int MASS_W     = btc_pkg::MASS_W;
    localparam int GRAV_W     = btc_pkg::GRAV_W;
    localparam int VGAIN_W    = btc_pkg::VGAIN_W;
    localparam int PGAIN_W    = btc_pkg::PGAIN_W;
    localparam int THR_W      = btc_pkg::THR_W;
    localparam int GFLOOR_W   = btc_pkg::GFLOOR_W;

    localparam int ST_COS   = 8;
    localparam int ST_PROD  = 9;
    localparam int D1_N     = PROD_W;
    localparam int ST_GAIN  = ST_PROD + D1_N + 1;
    localparam int D2_N     = QUO_W;
    localparam int ST_BOUND = ST_GAIN + D2_N + 1;
    localparam int ST_OUT   = ST_BOUND + 1;

    localparam logic signed [COS_W-1:0] COS_ONE = COS_W'(1 << FRAC_BITS);
    localparam logic [QUO_W-1:0] Q_POS_MAX = QUO_W'(33'h0_7FFF_FFFF);
    localparam logic [QUO_W-1:0] Q_NEG_MAX = QUO_W'(33'h0_8000_0000);

    typedef struct packed {
        logic [DATA_W-1:0] nom;
        logic [QUO_W-1:0]  mag;
        logic              nneg;
        logic              pos;
    } side_t;

    typedef struct packed {
        logic [DATA_W-1:0] nom;
        logic              nneg;
    } side2_t;

    // configuration registers
    logic [MASS_W-1:0]   mass_reg;
    logic [GRAV_W-1:0]   grav_reg;
    logic [VGAIN_W-1:0]  vgain_reg;
    logic [PGAIN_W-1:0]  pgain_reg;
    logic [THR_W-1:0]    ceil_reg;
    logic [THR_W-1:0]    floor_reg;
    logic [GFLOOR_W-1:0] gfloor_reg;

    logic [MASS_W-1:0]   mass_eff;
    logic [GFLOOR_W-1:0] gfloor_eff;

    logic adv;
    logic vld_reg [1:ST_OUT];

    // input unpacking and angle reduction
    logic signed [DATA_W-1:0] alt_in;
    logic signed [DATA_W-1:0] climb_in;
    logic [DATA_W-1:0]        nom_in;
    logic [ANG_W-1:0]         ang_in   [2];
    logic [31:0]              ang_ext  [2];
    logic [ANGLE_BITS-1:0]    ang_p    [2];
    logic [1:0]               quad     [2];
    logic [29:0]              frac_q   [2];
    logic [POLY_W-1:0]        g_in     [2];
    logic                     neg_in   [2];

    // cosine lanes: 0 roll, 1 pitch
    logic [POLY_W-1:0]        g1_reg   [2];
    logic                     neg_reg  [1:7][2];
    logic [POLY_W-1:0]        x_reg    [2:6][2];
    logic [POLY_W-1:0]        t_reg    [3:6][2];
    logic [POLY_W-1:0]        v7_reg   [2];
    logic signed [COS_W-1:0]  cos_reg  [2];
    logic [31:0]              vdiff    [2];
    logic [POLY_W-1:0]        vclamp   [2];
    logic [POLY_W-1:0]        vround   [2];

    // barrier numerator
    logic signed [VGAIN_W+DATA_W:0] pv_reg;
    logic signed [PGAIN_W+DATA_W:0] pp_reg;
    logic signed [NUM_W-1:0]        num2_reg;
    logic [NUM_W-1:0]               num_abs;
    logic [DATA_W-1:0]              nom1_reg;
    logic [DATA_W-1:0]              nom2_reg;
    side_t                          side_reg [3:ST_GAIN-1];

    // attitude product and gain divider
    logic signed [2*COS_W-1:0] cprod;
    logic                      cprod_pos;
    logic [PROD_W-1:0]         d1_dq_reg  [0:D1_N];
    logic [MASS_W-1:0]         d1_rem_reg [0:D1_N];
    logic [PROD_W-1:0]         gain_next;

    // bound divider
    logic [QUO_W-1:0]          d2_dq_reg   [0:D2_N];
    logic [PROD_W-1:0]         d2_rem_reg  [0:D2_N];
    logic [PROD_W-1:0]         d2_gain_reg [0:D2_N];
    side2_t                    side2_reg   [0:D2_N];

    logic [DATA_W-1:0]         bound_next;
    logic signed [DATA_W-1:0]  bound_reg;
    logic [DATA_W-1:0]         nomb_reg;

    logic signed [DATA_W-1:0]  lo_bound;
    logic signed [DATA_W-1:0]  ceil_s;
    logic [DATA_W-1:0]         m_tdata_next;
    logic [1:0]                m_tuser_next;
    logic [DATA_W-1:0]         m_tdata_reg;
    logic [1:0]                m_tuser_reg;

    function automatic logic [MASS_W+PROD_W-1:0] d1_step(input logic [MASS_W-1:0] rem,
                                                         input logic [PROD_W-1:0] dq,
                                                         input logic [MASS_W-1:0] dvs);
        logic [MASS_W:0] trial;
        logic [MASS_W:0] diff;
        trial = {rem, dq[PROD_W-1]};
        diff  = trial - {1'b0, dvs};
        if (trial >= {1'b0, dvs}) begin
            return {diff[MASS_W-1:0], dq[PROD_W-2:0], 1'b1};
        end else begin
            return {trial[MASS_W-1:0], dq[PROD_W-2:0], 1'b0};
        end
    endfunction

    function automatic logic [PROD_W+QUO_W-1:0] d2_step(input logic [PROD_W-1:0] rem,
                                                        input logic [QUO_W-1:0]  dq,
                                                        input logic [PROD_W-1:0] dvs);
        logic [PROD_W:0] trial;
        logic [PROD_W:0] diff;
        trial = {rem, dq[QUO_W-1]};
        diff  = trial - {1'b0, dvs};
        if (trial >= {1'b0, dvs}) begin
            return {diff[PROD_W-1:0], dq[QUO_W-2:0], 1'b1};
        end else begin
            return {trial[PROD_W-1:0], dq[QUO_W-2:0], 1'b0};
        end
    endfunction

    // ---------------- configuration ----------------

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg   <= btc_pkg::MASS_RST;
            grav_reg   <= btc_pkg::GRAV_RST;
            vgain_reg  <= btc_pkg::VGAIN_RST;
            pgain_reg  <= btc_pkg::PGAIN_RST;
            ceil_reg   <= btc_pkg::CEIL_RST;
            floor_reg  <= btc_pkg::FLOOR_RST;
            gfloor_reg <= btc_pkg::GFLOOR_RST;
        end else if (cfg_valid) begin
            case (btc_pkg::cfg_reg_t'(cfg_index))
                btc_pkg::REG_MASS:    mass_reg   <= cfg_data[MASS_W-1:0];
                btc_pkg::REG_GRAVITY: grav_reg   <= cfg_data[GRAV_W-1:0];
                btc_pkg::REG_VGAIN:   vgain_reg  <= cfg_data[VGAIN_W-1:0];
                btc_pkg::REG_PGAIN:   pgain_reg  <= cfg_data[PGAIN_W-1:0];
                btc_pkg::REG_CEILING: ceil_reg   <= cfg_data[THR_W-1:0];
                btc_pkg::REG_FLOOR:   floor_reg  <= cfg_data[THR_W-1:0];
                btc_pkg::REG_GFLOOR:  gfloor_reg <= cfg_data[GFLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    // zero mass or zero gain floor act as one lsb
    assign mass_eff   = (mass_reg == '0) ? MASS_W'(1) : mass_reg;
    assign gfloor_eff = (gfloor_reg == '0) ? GFLOOR_W'(1) : gfloor_reg;

    // ---------------- flow control ----------------

    assign adv      = !vld_reg[ST_OUT] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[ST_OUT];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= ST_OUT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[1] <= s_tvalid;
            for (int k = 2; k <= ST_OUT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ---------------- combinational helpers ----------------

    assign alt_in    = s_tdata[31:0];
    assign climb_in  = s_tdata[63:32];
    assign ang_in[0] = s_tdata[79:64];
    assign ang_in[1] = s_tdata[95:80];
    assign nom_in    = s_tdata[127:96];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            ang_ext[l] = 32'($signed(ang_in[l]));
            ang_p[l]   = ang_ext[l][ANGLE_BITS-1:0];
            quad[l]    = ang_p[l][ANGLE_BITS-1 -: 2];
            frac_q[l]  = {ang_p[l][ANGLE_BITS-3:0], (32-ANGLE_BITS)'(0)};
            // odd quadrants run the quarter wave backwards
            g_in[l]    = quad[l][0] ? (btc_pkg::ONE30 - {1'b0, frac_q[l]})
                                    : {1'b0, frac_q[l]};
            neg_in[l]  = quad[l][0] ^ quad[l][1];

            vdiff[l]   = {1'b0, btc_pkg::ONE30}
                       - {1'b0, btc_pkg::mul_shr30(x_reg[6][l], t_reg[6][l])};
            vclamp[l]  = vdiff[l][31] ? '0 : vdiff[l][POLY_W-1:0];
            vround[l]  = v7_reg[l] + btc_pkg::COS_RND;
        end
    end

    assign num_abs   = num2_reg[NUM_W-1] ? NUM_W'(-num2_reg) : NUM_W'(num2_reg);
    assign cprod     = cos_reg[0] * cos_reg[1];
    assign cprod_pos = !cprod[2*COS_W-1] && (cprod != '0);

    // gain below the floor, or not positive at all, takes the floor
    always_comb begin
        if (!side_reg[ST_GAIN-1].pos || d1_dq_reg[D1_N] < PROD_W'(gfloor_eff)) begin
            gain_next = PROD_W'(gfloor_eff);
        end else begin
            gain_next = d1_dq_reg[D1_N];
        end
    end

    // saturate the signed quotient to 32 bits
    always_comb begin
        if (!side2_reg[D2_N].nneg) begin
            bound_next = (d2_dq_reg[D2_N] > Q_POS_MAX) ? 32'h7FFF_FFFF
                                                       : d2_dq_reg[D2_N][DATA_W-1:0];
        end else begin
            bound_next = (d2_dq_reg[D2_N] > Q_NEG_MAX) ? 32'h8000_0000
                                                       : -d2_dq_reg[D2_N][DATA_W-1:0];
        end
    end

    // lower-bound test first, then the ceiling
    always_comb begin
        ceil_s   = $signed({1'b0, ceil_reg});
        lo_bound = (bound_reg > $signed({1'b0, floor_reg})) ? bound_reg
                                                            : $signed({1'b0, floor_reg});
        if ($signed(nomb_reg) < lo_bound) begin
            m_tdata_next = lo_bound;
            m_tuser_next = btc_pkg::KIND_RAISED;
        end else if ($signed(nomb_reg) > ceil_s) begin
            m_tdata_next = ceil_s;
            m_tuser_next = btc_pkg::KIND_CAPPED;
        end else begin
            m_tdata_next = nomb_reg;
            m_tuser_next = btc_pkg::KIND_PASS;
        end
    end

    // ---------------- datapath ----------------

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1: angle reduction, numerator products
            for (int l = 0; l < 2; l++) begin
                g1_reg[l]     <= g_in[l];
                neg_reg[1][l] <= neg_in[l];
            end
            pv_reg   <= $signed({1'b0, vgain_reg}) * climb_in;
            pp_reg   <= $signed({1'b0, pgain_reg}) * alt_in;
            nom1_reg <= nom_in;

            // stage 2: square of the reduced angle, numerator sum
            for (int l = 0; l < 2; l++) begin
                x_reg[2][l]   <= btc_pkg::mul_shr30(g1_reg[l], g1_reg[l]);
                neg_reg[2][l] <= neg_reg[1][l];
            end
            num2_reg <= $signed(NUM_W'({grav_reg, FRAC_BITS'(0)}))
                      - NUM_W'(pv_reg) - NUM_W'(pp_reg);
            nom2_reg <= nom1_reg;

            // stages 3 to 6: horner steps of the polynomial
            for (int l = 0; l < 2; l++) begin
                t_reg[3][l] <= btc_pkg::COS_C4 - btc_pkg::mul_shr30(x_reg[2][l], btc_pkg::COS_C5);
                t_reg[4][l] <= btc_pkg::COS_C3 - btc_pkg::mul_shr30(x_reg[3][l], t_reg[3][l]);
                t_reg[5][l] <= btc_pkg::COS_C2 - btc_pkg::mul_shr30(x_reg[4][l], t_reg[4][l]);
                t_reg[6][l] <= btc_pkg::COS_C1 - btc_pkg::mul_shr30(x_reg[5][l], t_reg[5][l]);
                for (int k = 3; k <= 6; k++) begin
                    x_reg[k][l] <= x_reg[k-1][l];
                end
                for (int k = 3; k <= 7; k++) begin
                    neg_reg[k][l] <= neg_reg[k-1][l];
                end
                // stage 7: last product, clamp at zero
                v7_reg[l] <= vclamp[l];
                // stage 8: round to the output format, apply the quadrant sign
                cos_reg[l] <= neg_reg[7][l] ? -$signed({1'b0, vround[l][POLY_W-1 -: FRAC_BITS+1]})
                                            : $signed({1'b0, vround[l][POLY_W-1 -: FRAC_BITS+1]});
            end

            // side fields ride along from stage 3 until the gain is known
            side_reg[3].nom  <= nom2_reg;
            side_reg[3].mag  <= num_abs[QUO_W-1:0];
            side_reg[3].nneg <= num2_reg[NUM_W-1];
            side_reg[3].pos  <= 1'b0;
            for (int k = 4; k < ST_GAIN; k++) begin
                if (k == ST_PROD) begin
                    side_reg[k].nom  <= side_reg[k-1].nom;
                    side_reg[k].mag  <= side_reg[k-1].mag;
                    side_reg[k].nneg <= side_reg[k-1].nneg;
                    side_reg[k].pos  <= cprod_pos;
                end else begin
                    side_reg[k] <= side_reg[k-1];
                end
            end

            // stage 9: attitude product enters the gain divider
            d1_dq_reg[0]  <= cprod[PROD_W-1:0];
            d1_rem_reg[0] <= '0;
            for (int j = 1; j <= D1_N; j++) begin
                {d1_rem_reg[j], d1_dq_reg[j]} <= d1_step(d1_rem_reg[j-1], d1_dq_reg[j-1],
                                                         mass_eff);
            end

            // gain stage loads the bound divider
            d2_dq_reg[0]      <= side_reg[ST_GAIN-1].mag;
            d2_rem_reg[0]     <= '0;
            d2_gain_reg[0]    <= gain_next;
            side2_reg[0].nom  <= side_reg[ST_GAIN-1].nom;
            side2_reg[0].nneg <= side_reg[ST_GAIN-1].nneg;
            for (int j = 1; j <= D2_N; j++) begin
                {d2_rem_reg[j], d2_dq_reg[j]} <= d2_step(d2_rem_reg[j-1], d2_dq_reg[j-1],
                                                         d2_gain_reg[j-1]);
                d2_gain_reg[j] <= d2_gain_reg[j-1];
                side2_reg[j]   <= side2_reg[j-1];
            end

            bound_reg   <= bound_next;
            nomb_reg    <= side2_reg[D2_N].nom;

            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    // ---------------- assertions ----------------

    `ASSERT_CLK(a_cos_range, vld_reg[ST_COS] |-> (cos_reg[0] <= COS_ONE) && (cos_reg[0] >= -COS_ONE) && (cos_reg[1] <= COS_ONE) && (cos_reg[1] >= -COS_ONE), "cosine outside unit range")
    `ASSERT_CLK(a_gain_nonzero, vld_reg[ST_GAIN] |-> (d2_gain_reg[0] != '0), "bound divisor is zero")
    `ASSERT_CLK(a_rem_below_gain, vld_reg[ST_BOUND-1] |-> (d2_rem_reg[D2_N] < d2_gain_reg[D2_N]), "bound divider remainder not below divisor")
    `ASSERT_ALWAYS(a_stall_only_full, (s_tvalid && !s_tready) |-> vld_reg[ST_OUT], "input stalled with empty output register")

endmodule

`default_nettype wire
